// ----- hdl/perturb_observe_2d_optimizer_assert.svh -----
`ifndef PERTURB_OBSERVE_2D_OPTIMIZER_ASSERT_SVH
`define PERTURB_OBSERVE_2D_OPTIMIZER_ASSERT_SVH

// Both macros expect clk and arst_n in the scope where they are used.

`define PO2D_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("po2d: same-cycle check failed");

`define PO2D_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("po2d: next-cycle check failed");

`endif

// ----- hdl/po2d_pkg.sv -----
package po2d_pkg;

	localparam int VALUE_WIDTH_DEF = 16;
	localparam int ANGLE_TABLE_DEPTH_DEF = 256;
	localparam int RAND_W = 16;
	localparam int BACKED_W = 2;
	localparam int CFG_INDEX_W = 2;

	localparam logic [1:0] MODE_RESET = 2'd0;
	localparam logic CLIMB_RESET = 1'b1;
	localparam int STEP_RESET = 205;
	localparam int GAIN_RESET = 8192;

	localparam logic [1:0] MODE_SMART = 2'd1;
	localparam logic [1:0] MODE_GRADIENT = 2'd2;

	localparam logic [BACKED_W-1:0] BACKED_NONE = 2'd0;
	localparam logic [BACKED_W-1:0] BACKED_SINGLE = 2'd1;
	localparam logic [BACKED_W-1:0] BACKED_DOUBLE = 2'd2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MODE  = 2'd0,
		CFG_CLIMB = 2'd1,
		CFG_STEP  = 2'd2,
		CFG_GAIN  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MUL_DX_DELTA,
		MUL_TX_GAIN,
		MUL_DY_DELTA,
		MUL_TY_GAIN,
		MUL_DX_STEP,
		MUL_DY_STEP
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		logic     prep;
		logic     pick_dir;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     grad_x;
		logic     correct;
		logic     move_x;
		logic     move_y;
		logic     load_out;
	} po2d_cmd_t;

	typedef struct packed {
		logic out_free;
	} po2d_status_t;

	// Sine of a quarter turn is built from a six-term Taylor series in Q30.
	localparam logic [63:0] Q30 = 64'd1 << 30;
	localparam logic [63:0] TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

endpackage

// ----- hdl/po2d_if.sv -----
interface po2d_in_if import po2d_pkg::*; #(parameter int VALUE_WIDTH = VALUE_WIDTH_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] level;
	logic [RAND_W-1:0]             rand_a;
	logic [RAND_W-1:0]             rand_b;

	modport source (output valid, output level, output rand_a, output rand_b, input ready);
	modport sink (input valid, input level, input rand_a, input rand_b, output ready);
endinterface

interface po2d_out_if import po2d_pkg::*; #(parameter int VALUE_WIDTH = VALUE_WIDTH_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] x_offset;
	logic signed [VALUE_WIDTH-1:0] y_offset;
	logic [BACKED_W-1:0]           backed_off;

	modport source (output valid, output x_offset, output y_offset, output backed_off,
		input ready);
	modport sink (input valid, input x_offset, input y_offset, input backed_off,
		output ready);
endinterface

interface po2d_cfg_if import po2d_pkg::*; #(parameter int VALUE_WIDTH = VALUE_WIDTH_DEF);
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [VALUE_WIDTH-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/perturb_observe_2d_optimizer.sv -----
// Two-axis perturb-and-observe optimizer.
// The meas channel takes one beat per averaged detector level, with two random
// draws. The result channel returns one beat per measurement beat: the new X/Y
// drive position in signed fixed point, saturated to plus or minus one, and the
// step-back taken. The cfg channel writes mode, climb_enable, step_size and gain
// by register index; it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. A measurement beat is taken when
// the block is idle; it then steps through prep, four multiplies, correction, two
// move multiplies, the Y add and emit, and loads its result into the output register
// on leaving emit, when meas turns ready again. The sequence is set by the single
// shared multiplier, used six times per item, plus table read, correction and load.
// If the receiver stalls, the finished result stays in the output register and
// the block holds its last step until that register is free; meas stays not
// ready in the meantime.
// Reset clears the position, direction, move and last level to zero, and sets
// the registers to mode 0, climbing on, step size 205 and gain 8192.
`include "perturb_observe_2d_optimizer_assert.svh"

module perturb_observe_2d_optimizer import po2d_pkg::*; #(
	parameter int ANGLE_TABLE_DEPTH = ANGLE_TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	po2d_in_if.sink      meas,
	po2d_out_if.source   result,
	po2d_cfg_if.sink     cfg
);

	localparam logic signed [VALUE_WIDTH-1:0] POS_MAX = {2'b01, {(VALUE_WIDTH-2){1'b0}}};
	localparam logic signed [VALUE_WIDTH-1:0] POS_MIN = {2'b11, {(VALUE_WIDTH-2){1'b0}}};

	po2d_cmd_t    cmd;
	po2d_status_t status;
	logic         meas_ready;

	assign meas.ready = meas_ready;

	po2d_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.meas_valid (meas.valid),
		.meas_ready (meas_ready),
		.status     (status),
		.cmd        (cmd)
	);

	po2d_datapath #(
		.ANGLE_TABLE_DEPTH (ANGLE_TABLE_DEPTH),
		.VALUE_WIDTH       (VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.level      (meas.level),
		.rand_a     (meas.rand_a),
		.rand_b     (meas.rand_b),
		.cfg_valid  (cfg.valid),
		.cfg_ready  (cfg.ready),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.x_offset   (result.x_offset),
		.y_offset   (result.y_offset),
		.backed_off (result.backed_off)
	);

	`PO2D_ASSERT_SAME(a_x_in_range, result.valid, result.x_offset <= POS_MAX && result.x_offset >= POS_MIN)
	`PO2D_ASSERT_SAME(a_y_in_range, result.valid, result.y_offset <= POS_MAX && result.y_offset >= POS_MIN)
	`PO2D_ASSERT_NEXT(a_one_item_at_a_time, meas.valid && meas.ready, !meas.ready)

endmodule

// ----- hdl/po2d_ctrl.sv -----
module po2d_ctrl import po2d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         meas_valid,
	output logic         meas_ready,
	input  po2d_status_t status,
	output po2d_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_MUL_DX,
		S_MUL_TX,
		S_MUL_DY,
		S_MUL_TY,
		S_CORRECT,
		S_MUL_MX,
		S_MUL_MY,
		S_ADD_Y,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign meas_ready = ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (meas_valid && ready_q) begin
						state_q <= S_PREP;
						ready_q <= 1'b0;
					end
				end
				S_PREP:    state_q <= S_MUL_DX;
				S_MUL_DX:  state_q <= S_MUL_TX;
				S_MUL_TX:  state_q <= S_MUL_DY;
				S_MUL_DY:  state_q <= S_MUL_TY;
				S_MUL_TY:  state_q <= S_CORRECT;
				S_CORRECT: state_q <= S_MUL_MX;
				S_MUL_MX:  state_q <= S_MUL_MY;
				S_MUL_MY:  state_q <= S_ADD_Y;
				S_ADD_Y:   state_q <= S_EMIT;
				S_EMIT: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_DX_DELTA;
		unique case (state_q)
			S_IDLE:    cmd.capture = meas_valid && ready_q;
			S_PREP:    cmd.prep = 1'b1;
			S_MUL_DX: begin
				cmd.pick_dir = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_DX_DELTA;
			end
			S_MUL_TX: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_TX_GAIN;
			end
			S_MUL_DY: begin
				cmd.grad_x = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_DY_DELTA;
			end
			S_MUL_TY: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_TY_GAIN;
			end
			S_CORRECT: cmd.correct = 1'b1;
			S_MUL_MX: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_DX_STEP;
			end
			S_MUL_MY: begin
				cmd.move_x = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_DY_STEP;
			end
			S_ADD_Y:   cmd.move_y = 1'b1;
			S_EMIT:    cmd.load_out = status.out_free;
			default:   cmd.capture = 1'b0;
		endcase
	end

endmodule

// ----- hdl/po2d_datapath.sv -----
module po2d_datapath import po2d_pkg::*; #(
	parameter int ANGLE_TABLE_DEPTH = ANGLE_TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  po2d_cmd_t                     cmd,
	output po2d_status_t                  status,
	input  logic signed [VALUE_WIDTH-1:0] level,
	input  logic [RAND_W-1:0]             rand_a,
	input  logic [RAND_W-1:0]             rand_b,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [VALUE_WIDTH-1:0]        cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [VALUE_WIDTH-1:0] x_offset,
	output logic signed [VALUE_WIDTH-1:0] y_offset,
	output logic [BACKED_W-1:0]           backed_off
);

	localparam int VW = VALUE_WIDTH;
	localparam int F = VW - 2;
	localparam int MW = VW + 1;
	localparam int PW = 2 * MW;
	localparam int CW = VW + 2;
	localparam int DW = MW + 5;
	localparam int AW = $clog2(ANGLE_TABLE_DEPTH);
	localparam int KW = AW + 17;
	localparam int SH = 32 - VW;
	localparam logic [63:0] ONE64 = 64'd1 << F;
	localparam logic signed [CW-1:0] POS_HI = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
	localparam logic signed [CW-1:0] POS_LO = -POS_HI;
	localparam logic signed [PW-1:0] GLIM = {{(PW-VW-1){1'b0}}, 1'b1, {VW{1'b0}}};
	localparam logic signed [PW-1:0] GLIM_N = -GLIM;

	typedef enum logic [1:0] {CORR_NONE, CORR_GRAD, CORR_BACK1, CORR_BACK2} corr_t;

	function automatic logic [63:0] sin_quarter(input logic [63:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x = (r * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		t = Q30;
		for (int i = 0; i < 5; i++) begin
			t = Q30 - (((x2 * t) >> 30) / TAYLOR_DIV[i]);
		end
		return (x * t) >> 30;
	endfunction

	function automatic logic signed [VW-1:0] sin_turn(input logic [31:0] ph);
		logic [63:0] r;
		logic [63:0] m;
		r = {34'd0, ph[29:0]};
		if (ph[30]) begin
			r = Q30 - r;
		end
		m = sin_quarter(r);
		if (SH > 0) begin
			m = (m + (64'd1 << (SH - 1))) >> SH;
		end
		if (m > ONE64) begin
			m = ONE64;
		end
		return ph[31] ? VW'(64'd0 - m) : VW'(m);
	endfunction

	function automatic logic signed [VW-1:0] sat_one(input logic signed [CW-1:0] v);
		if (v > POS_HI) begin
			return VW'(POS_HI);
		end else if (v < POS_LO) begin
			return VW'(POS_LO);
		end
		return VW'(v);
	endfunction

	function automatic logic signed [CW-1:0] clamp_grad(input logic signed [PW-1:0] v);
		if (v > GLIM) begin
			return CW'(GLIM);
		end else if (v < GLIM_N) begin
			return CW'(GLIM_N);
		end
		return CW'(v);
	endfunction

	function automatic logic signed [CW-1:0] corrected(
		input logic signed [VW-1:0] p,
		input logic signed [VW-1:0] mv,
		input logic signed [CW-1:0] g,
		input corr_t                sel
	);
		logic signed [CW-1:0] pc;
		logic signed [CW-1:0] mc;
		pc = CW'(p);
		mc = CW'(mv);
		unique case (sel)
			CORR_NONE:  return pc;
			CORR_GRAD:  return pc + g;
			CORR_BACK1: return pc - mc;
			CORR_BACK2: return pc - (mc <<< 1);
		endcase
	endfunction

	logic signed [VW-1:0] cos_rom [ANGLE_TABLE_DEPTH];
	logic signed [VW-1:0] sin_rom [ANGLE_TABLE_DEPTH];

	for (genvar g = 0; g < ANGLE_TABLE_DEPTH; g++) begin : g_rom
		localparam logic [31:0] PH =
			32'(((64'(g) << 32) / ANGLE_TABLE_DEPTH) + 64'h8000_0000);
		assign cos_rom[g] = sin_turn(PH + 32'h4000_0000);
		assign sin_rom[g] = sin_turn(PH);
	end

	logic [1:0]           mode_q;
	logic                 climb_q;
	logic [VW-2:0]        step_q;
	logic [VW-1:0]        gain_q;

	logic signed [VW-1:0] pos_x_q;
	logic signed [VW-1:0] pos_y_q;
	logic signed [VW-1:0] dir_x_q;
	logic signed [VW-1:0] dir_y_q;
	logic signed [VW-1:0] move_x_q;
	logic signed [VW-1:0] move_y_q;
	logic signed [VW-1:0] last_q;

	logic signed [VW-1:0] level_q;
	logic [RAND_W-1:0]    ra_q;
	logic [RAND_W-1:0]    rb_q;
	logic signed [MW-1:0] delta_q;
	logic [AW-1:0]        k_q;
	logic signed [VW-1:0] ndx_q;
	logic signed [VW-1:0] ndy_q;
	logic signed [PW-1:0] prod_q;
	logic signed [CW-1:0] gx_q;
	logic [BACKED_W-1:0]  backed_q;

	logic                 out_valid_q;
	logic signed [VW-1:0] x_out_q;
	logic signed [VW-1:0] y_out_q;
	logic [BACKED_W-1:0]  backed_out_q;

	logic                 is_grad;
	logic                 is_smart;
	logic [KW-1:0]        k_prod;
	logic signed [16:0]   ux_d;
	logic signed [16:0]   uy_d;
	logic signed [F+16:0] ux_w;
	logic signed [F+16:0] uy_w;
	logic signed [F+16:0] ux_sh;
	logic signed [F+16:0] uy_sh;
	logic signed [MW-1:0] mul_a;
	logic signed [MW-1:0] mul_b;
	logic signed [PW-1:0] prod_sh;
	logic signed [CW-1:0] gy;
	logic signed [DW-1:0] delta_ext;
	logic signed [DW-1:0] drop20;
	logic                 drop;
	logic                 big_drop;
	corr_t                corr_sel;
	logic [BACKED_W-1:0]  backed_code;
	logic signed [VW-1:0] new_last;
	logic signed [VW-1:0] mv;

	assign is_grad = (mode_q == MODE_GRADIENT);
	assign is_smart = (mode_q == MODE_SMART);

	assign k_prod = KW'(ra_q) * KW'(ANGLE_TABLE_DEPTH);

	assign ux_d = $signed({1'b0, ra_q}) - 17'sd32768;
	assign uy_d = $signed({1'b0, rb_q}) - 17'sd32768;
	assign ux_w = {ux_d, {F{1'b0}}};
	assign uy_w = {uy_d, {F{1'b0}}};
	assign ux_sh = ux_w >>> 15;
	assign uy_sh = uy_w >>> 15;

	assign prod_sh = prod_q >>> F;
	assign gy = clamp_grad(prod_sh);
	assign mv = prod_sh[VW-1:0];

	// The larger drop test compares step_size against twenty times the level fall.
	assign delta_ext = {{(DW-MW){delta_q[MW-1]}}, delta_q};
	assign drop20 = -(delta_ext <<< 4) - (delta_ext <<< 2);
	assign drop = delta_q[MW-1];
	assign big_drop = $signed({{(DW-VW+1){1'b0}}, step_q}) < drop20;

	always_comb begin
		priority if (is_grad) begin
			corr_sel = CORR_GRAD;
		end else if (is_smart) begin
			corr_sel = drop ? CORR_BACK1 : CORR_NONE;
		end else if (big_drop) begin
			corr_sel = CORR_BACK2;
		end else if (drop) begin
			corr_sel = CORR_BACK1;
		end else begin
			corr_sel = CORR_NONE;
		end
	end

	always_comb begin
		unique case (corr_sel)
			CORR_BACK1: backed_code = BACKED_SINGLE;
			CORR_BACK2: backed_code = BACKED_DOUBLE;
			CORR_NONE:  backed_code = BACKED_NONE;
			CORR_GRAD:  backed_code = BACKED_NONE;
		endcase
	end

	assign new_last = (is_smart && drop) ? last_q : level_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mul_sel)
			MUL_DX_DELTA: begin
				mul_a = {dir_x_q[VW-1], dir_x_q};
				mul_b = delta_q;
			end
			MUL_TX_GAIN: begin
				mul_a = prod_sh[MW-1:0];
				mul_b = {1'b0, gain_q};
			end
			MUL_DY_DELTA: begin
				mul_a = {dir_y_q[VW-1], dir_y_q};
				mul_b = delta_q;
			end
			MUL_TY_GAIN: begin
				mul_a = prod_sh[MW-1:0];
				mul_b = {1'b0, gain_q};
			end
			MUL_DX_STEP: begin
				mul_a = {dir_x_q[VW-1], dir_x_q};
				mul_b = {2'b00, step_q};
			end
			MUL_DY_STEP: begin
				mul_a = {dir_y_q[VW-1], dir_y_q};
				mul_b = {2'b00, step_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
			climb_q <= CLIMB_RESET;
			step_q <= (VW-1)'(STEP_RESET);
			gain_q <= VW'(GAIN_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MODE:  mode_q <= cfg_data[1:0];
				CFG_CLIMB: climb_q <= cfg_data[0];
				CFG_STEP:  step_q <= cfg_data[VW-2:0];
				CFG_GAIN:  gain_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			dir_x_q <= '0;
			dir_y_q <= '0;
			move_x_q <= '0;
			move_y_q <= '0;
			last_q <= '0;
		end else begin
			if (cmd.correct) begin
				pos_x_q <= sat_one(corrected(pos_x_q, move_x_q, gx_q, corr_sel));
				pos_y_q <= sat_one(corrected(pos_y_q, move_y_q, gy, corr_sel));
				last_q <= new_last;
				if (climb_q) begin
					dir_x_q <= ndx_q;
					dir_y_q <= ndy_q;
				end
			end
			if (cmd.move_x && climb_q) begin
				move_x_q <= mv;
				pos_x_q <= sat_one(CW'(pos_x_q) + CW'(mv));
			end
			if (cmd.move_y && climb_q) begin
				move_y_q <= mv;
				pos_y_q <= sat_one(CW'(pos_y_q) + CW'(mv));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			level_q <= level;
			ra_q <= rand_a;
			rb_q <= rand_b;
		end
		if (cmd.prep) begin
			delta_q <= {level_q[VW-1], level_q} - {last_q[VW-1], last_q};
			k_q <= k_prod[AW+15:16];
		end
		if (cmd.pick_dir) begin
			ndx_q <= is_grad ? cos_rom[k_q] : ux_sh[VW-1:0];
			ndy_q <= is_grad ? sin_rom[k_q] : uy_sh[VW-1:0];
		end
		if (cmd.mul_en) begin
			prod_q <= PW'(mul_a) * PW'(mul_b);
		end
		if (cmd.grad_x) begin
			gx_q <= clamp_grad(prod_sh);
		end
		if (cmd.correct) begin
			backed_q <= backed_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			x_out_q <= pos_x_q;
			y_out_q <= pos_y_q;
			backed_out_q <= backed_q;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign x_offset = x_out_q;
	assign y_offset = y_out_q;
	assign backed_off = backed_out_q;

endmodule

// ----- tb/sv/tb.sv -----
module tb;
	import po2d_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 14;
	localparam longint ONE = longint'(1) << FRAC;
	localparam longint PULL_LIMIT = 4 * ONE;
	localparam longint ANGLE_DEPTH = 256;
	localparam bit [63:0] QUARTER_ONE = 64'd1 << 30;
	localparam bit [63:0] SERIES_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
	localparam logic [1:0] MODE_TWO_LEVEL = 2'd0;
	localparam logic [1:0] MODE_ALIAS = 2'd3;
	localparam int RANDOM_READINGS = 600;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [15:0] x_off;
		logic signed [15:0] y_off;
		logic [1:0]         backed;
	} position_t;

	typedef struct {
		bit                 is_write;
		cfg_reg_t           sel;
		logic [15:0]        value;
		logic signed [15:0] level;
		logic [15:0]        ra;
		logic [15:0]        rb;
		bit                 known;
		position_t          outcome;
	} plan_row_t;

	logic clk;
	logic arst_n;

	po2d_in_if meas ();
	po2d_out_if result ();
	po2d_cfg_if cfg ();

	perturb_observe_2d_optimizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.meas(meas),
		.result(result),
		.cfg(cfg)
	);

	logic [1:0] tune_mode;
	bit tune_climb;
	longint tune_step;
	longint tune_gain;
	longint pos_x, pos_y, dir_x, dir_y, move_x, move_y, prev_level;

	position_t pending_positions[$];
	plan_row_t opening_plan[$];
	int error_count;
	int cycle_count;
	bit reading_live;
	bit write_live;
	longint hill_x, hill_y;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	function automatic longint clamp_one(longint v);
		if (v > ONE)
			return ONE;
		if (v < -ONE)
			return -ONE;
		return v;
	endfunction

	function automatic bit [63:0] quarter_sine(bit [63:0] r);
		bit [63:0] x;
		bit [63:0] x2;
		bit [63:0] t;
		x = (r * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		t = QUARTER_ONE;
		for (int i = 0; i < 5; i++)
			t = QUARTER_ONE - ((x2 * t) >> 30) / SERIES_DIV[i];
		return (x * t) >> 30;
	endfunction

	function automatic longint turn_sine(bit [31:0] phase);
		bit [63:0] r;
		bit [63:0] m;
		r = {34'd0, phase[29:0]};
		if (phase[30])
			r = QUARTER_ONE - r;
		m = quarter_sine(r);
		m = (m + 64'd32768) >> 16;
		if (m > 64'(ONE))
			m = 64'(ONE);
		return phase[31] ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint gradient_pull(longint dir, longint delta);
		longint t;
		longint c;
		t = (dir * delta) >>> FRAC;
		if (tune_gain == 0 || t == 0)
			return 0;
		c = (t * tune_gain) >>> FRAC;
		if (c > PULL_LIMIT)
			c = PULL_LIMIT;
		if (c < -PULL_LIMIT)
			c = -PULL_LIMIT;
		return c;
	endfunction

	function automatic position_t climb_step(logic signed [15:0] level, logic [15:0] ra,
		logic [15:0] rb);
		longint lv;
		longint delta;
		longint keep_level;
		bit [63:0] slot;
		bit [31:0] phase;
		position_t p;
		lv = longint'(level);
		delta = lv - prev_level;
		keep_level = lv;
		p.backed = BACKED_NONE;
		if (tune_mode == MODE_GRADIENT) begin
			pos_x += gradient_pull(dir_x, delta);
			pos_y += gradient_pull(dir_y, delta);
		end else if (tune_mode == MODE_SMART) begin
			if (lv < prev_level) begin
				pos_x -= move_x;
				pos_y -= move_y;
				keep_level = prev_level;
				p.backed = BACKED_SINGLE;
			end
		end else begin
			if (lv + tune_step / 20 < prev_level) begin
				pos_x -= 2 * move_x;
				pos_y -= 2 * move_y;
				p.backed = BACKED_DOUBLE;
			end else if (lv < prev_level) begin
				pos_x -= move_x;
				pos_y -= move_y;
				p.backed = BACKED_SINGLE;
			end
		end
		pos_x = clamp_one(pos_x);
		pos_y = clamp_one(pos_y);
		prev_level = keep_level;
		if (tune_climb) begin
			if (tune_mode == MODE_GRADIENT) begin
				slot = (64'(ra) * 64'(ANGLE_DEPTH)) >> 16;
				slot = ((slot << 32) / 64'(ANGLE_DEPTH)) + 64'h8000_0000;
				phase = slot[31:0];
				dir_x = turn_sine(phase + 32'h4000_0000);
				dir_y = turn_sine(phase);
			end else begin
				dir_x = ((longint'(ra) - 32768) * ONE) >>> 15;
				dir_y = ((longint'(rb) - 32768) * ONE) >>> 15;
			end
			move_x = (dir_x * tune_step) >>> FRAC;
			move_y = (dir_y * tune_step) >>> FRAC;
			pos_x = clamp_one(pos_x + move_x);
			pos_y = clamp_one(pos_y + move_y);
		end
		p.x_off = pos_x[15:0];
		p.y_off = pos_y[15:0];
		return p;
	endfunction

	task automatic offer_reading(logic signed [15:0] level, logic [15:0] ra, logic [15:0] rb,
		bit known, position_t outcome);
		position_t p;
		if (write_live) begin
			cfg.valid <= 1'b0;
			write_live = 1'b0;
		end
		meas.valid <= 1'b1;
		meas.level <= level;
		meas.rand_a <= ra;
		meas.rand_b <= rb;
		reading_live = 1'b1;
		@(posedge clk);
		while (!meas.ready)
			@(posedge clk);
		p = climb_step(level, ra, rb);
		pending_positions.push_back(known ? outcome : p);
	endtask

	task automatic pause_readings(int cycles);
		if (cycles > 0) begin
			if (reading_live) begin
				meas.valid <= 1'b0;
				reading_live = 1'b0;
			end
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic write_register(cfg_reg_t sel, logic [15:0] value);
		if (reading_live) begin
			meas.valid <= 1'b0;
			reading_live = 1'b0;
		end
		while (pending_positions.size() != 0)
			@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= sel;
		cfg.data <= value;
		write_live = 1'b1;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (sel)
			CFG_MODE: tune_mode = value[1:0];
			CFG_CLIMB: tune_climb = value[0];
			CFG_STEP: tune_step = longint'(value[14:0]);
			CFG_GAIN: tune_gain = longint'(value);
			default: ;
		endcase
	endtask

	function automatic void plan_write(cfg_reg_t sel, logic [15:0] value);
		plan_row_t r;
		r = '{sel: CFG_MODE, default: '0};
		r.is_write = 1'b1;
		r.sel = sel;
		r.value = value;
		opening_plan.push_back(r);
	endfunction

	function automatic void plan_reading(logic signed [15:0] level, logic [15:0] ra,
		logic [15:0] rb, bit known = 1'b0, logic signed [15:0] ex = '0,
		logic signed [15:0] ey = '0, logic [1:0] eb = BACKED_NONE);
		plan_row_t r;
		r = '{sel: CFG_MODE, default: '0};
		r.level = level;
		r.ra = ra;
		r.rb = rb;
		r.known = known;
		r.outcome.x_off = ex;
		r.outcome.y_off = ey;
		r.outcome.backed = eb;
		opening_plan.push_back(r);
	endfunction

	function automatic logic signed [15:0] pick_level();
		longint lv;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			lv = 16000 - ((pos_x > hill_x ? pos_x - hill_x : hill_x - pos_x)
				+ (pos_y > hill_y ? pos_y - hill_y : hill_y - pos_y)) / 2;
			lv += longint'($urandom_range(0, 80)) - 40;
		end else if (pick < 80) begin
			lv = prev_level + longint'($urandom_range(0, 60)) - 30;
		end else begin
			lv = longint'($signed(16'($urandom)));
		end
		if (lv > 32767)
			lv = 32767;
		if (lv < -32768)
			lv = -32768;
		return lv[15:0];
	endfunction

	initial begin
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int calm_left;
			int stall_left;
			bit take;
			@(posedge clk);
			if (calm_left > 0) begin
				calm_left--;
				take = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				take = 1'b0;
			end else begin
				case ($urandom_range(0, 15))
					0: begin
						calm_left = $urandom_range(20, 120);
						take = 1'b1;
					end
					1, 2: begin
						stall_left = $urandom_range(1, 14);
						take = 1'b0;
					end
					3: take = 1'b0;
					default: take = 1'b1;
				endcase
			end
			result.ready <= take;
		end
	end

	always @(posedge clk) begin
		position_t want;
		if (arst_n && result.valid && result.ready) begin
			if (pending_positions.size() == 0) begin
				$error("result beat with no expectation: x_offset %0d y_offset %0d",
					result.x_offset, result.y_offset);
				error_count++;
			end else begin
				want = pending_positions.pop_front();
				if (result.x_offset !== want.x_off) begin
					$error("x_offset expected %0d got %0d", want.x_off, result.x_offset);
					error_count++;
				end
				if (result.y_offset !== want.y_off) begin
					$error("y_offset expected %0d got %0d", want.y_off, result.y_offset);
					error_count++;
				end
				if (result.backed_off !== want.backed) begin
					$error("backed_off expected %0d got %0d", want.backed, result.backed_off);
					error_count++;
				end
			end
		end
	end

	initial begin
		int burst_left;
		int sent;
		int phase_len;
		logic [15:0] v;
		position_t none;
		none = '{default: '0};
		arst_n = 1'b0;
		meas.valid <= 1'b0;
		meas.level <= '0;
		meas.rand_a <= '0;
		meas.rand_b <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= CFG_MODE;
		cfg.data <= '0;
		tune_mode = MODE_RESET;
		tune_climb = CLIMB_RESET;
		tune_step = longint'(STEP_RESET);
		tune_gain = longint'(GAIN_RESET);
		{pos_x, pos_y, dir_x, dir_y, move_x, move_y, prev_level} = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan_reading(16'sd0, 16'h8000, 16'h8000, 1'b1, 16'sd0, 16'sd0, BACKED_NONE);
		plan_reading(16'sd0, 16'hFFFF, 16'h0000, 1'b1, 16'sd204, -16'sd205, BACKED_NONE);
		plan_reading(-16'sd32768, 16'h8000, 16'h8000, 1'b1, -16'sd204, 16'sd205,
			BACKED_DOUBLE);
		plan_reading(-16'sd32763, 16'h0000, 16'hFFFF, 1'b1, -16'sd409, 16'sd409,
			BACKED_NONE);
		plan_reading(-16'sd32768, 16'h8000, 16'h8000, 1'b1, -16'sd204, 16'sd205,
			BACKED_SINGLE);
		plan_write(CFG_STEP, 16'd16384);
		plan_reading(16'sd32767, 16'hFFFF, 16'hFFFF);
		plan_reading(16'sd32767, 16'h0000, 16'h0000);
		plan_write(CFG_MODE, 16'(MODE_ALIAS));
		plan_reading(-16'sd32768, 16'h0000, 16'hFFFF);
		plan_reading(16'sd0, 16'h3039, 16'hD431);
		plan_write(CFG_MODE, 16'(MODE_SMART));
		plan_write(CFG_STEP, 16'd0);
		plan_reading(-16'sd100, 16'hAAAA, 16'h5555);
		plan_reading(-16'sd50, 16'h5555, 16'hAAAA);
		plan_write(CFG_STEP, 16'd4000);
		plan_reading(16'sd10, 16'hC350, 16'h2710);
		plan_reading(16'sd5, 16'h1234, 16'hFEDC);
		plan_write(CFG_MODE, 16'(MODE_GRADIENT));
		plan_write(CFG_GAIN, 16'hFFFF);
		plan_reading(16'sd32767, 16'h0000, 16'h0000);
		plan_reading(-16'sd32768, 16'hFFFF, 16'h7F00);
		plan_write(CFG_GAIN, 16'd0);
		plan_reading(16'sd1000, 16'h4000, 16'h0000);
		plan_write(CFG_CLIMB, 16'd0);
		plan_reading(16'sd2000, 16'h8000, 16'h0000);
		plan_write(CFG_MODE, 16'(MODE_TWO_LEVEL));
		plan_reading(-16'sd32768, 16'h0000, 16'h0000);
		plan_reading(-16'sd32768, 16'hFFFF, 16'hFFFF);
		plan_write(CFG_CLIMB, 16'd1);
		plan_write(CFG_STEP, 16'h7FFF);
		plan_reading(16'sd300, 16'h00FF, 16'hFF00);

		foreach (opening_plan[i]) begin
			if (opening_plan[i].is_write)
				write_register(opening_plan[i].sel, opening_plan[i].value);
			else
				offer_reading(opening_plan[i].level, opening_plan[i].ra, opening_plan[i].rb,
					opening_plan[i].known, opening_plan[i].outcome);
		end

		sent = 0;
		while (sent < RANDOM_READINGS) begin
			v = 16'($urandom);
			v[1:0] = 2'($urandom_range(0, 3));
			write_register(CFG_MODE, v);
			v = 16'($urandom);
			v[0] = ($urandom_range(0, 9) != 0);
			write_register(CFG_CLIMB, v);
			case ($urandom_range(0, 5))
				0: v = 16'd0;
				1: v = 16'd16384;
				2: v = 16'h7FFF;
				3, 4: v = 16'($urandom_range(1, 1500));
				default: v = 16'($urandom_range(0, 16384));
			endcase
			v[15] = 1'($urandom_range(0, 1));
			write_register(CFG_STEP, v);
			case ($urandom_range(0, 4))
				0: v = 16'd0;
				1: v = 16'hFFFF;
				2: v = 16'($urandom_range(4096, 12288));
				default: v = 16'($urandom);
			endcase
			write_register(CFG_GAIN, v);
			hill_x = longint'($urandom_range(0, 32768)) - 16384;
			hill_y = longint'($urandom_range(0, 32768)) - 16384;
			phase_len = $urandom_range(20, 60);
			burst_left = 0;
			for (int n = 0; n < phase_len; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					pause_readings(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
				end
				offer_reading(pick_level(), 16'($urandom), 16'($urandom), 1'b0, none);
				burst_left--;
				sent++;
			end
		end

		if (reading_live)
			meas.valid <= 1'b0;
		if (write_live)
			cfg.valid <= 1'b0;
		while (pending_positions.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (error_count == 0 && pending_positions.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
